>>> hdl/pstc_pkg.sv
// ----------------------------------------------------------------------------
// Sample converter package
// Format codes and the bit-level conversion functions shared by the pipeline.
// ----------------------------------------------------------------------------
package pstc_pkg;

  typedef enum logic [1:0] {
    FMT_UNORM = 2'd0,
    FMT_HALF  = 2'd1,
    FMT_FLOAT = 2'd2,
    FMT_NONE  = 2'd3
  } fmt_t;

  // Leading-one position of a non-zero word, as a priority encoder.
  function automatic logic [4:0] lead_one(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // Half to float is exact: subnormals are normalised by the leading one.
  function automatic logic [31:0] expand_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [4:0]  p;
    logic [9:0]  mn;
    logic [7:0]  fe;
    sgn = {h[15], 31'd0};
    e   = h[14:10];
    m   = h[9:0];
    p   = lead_one({22'd0, m});
    mn  = 10'(m << (5'd10 - p));
    fe  = 8'd103 + {3'd0, p};
    if (e == 5'h1f) return sgn | 32'h7f80_0000 | {9'd0, m, 13'd0};
    if (e == 5'd0) begin
      if (m == 10'd0) return sgn;
      return sgn | {1'b0, fe, mn, 13'd0};
    end
    return sgn | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
  endfunction

endpackage

>>> hdl/pixel_sample_type_converter.sv
// ----------------------------------------------------------------------------
// Pixel sample type converter
// Converts 32-bit samples between unorm32, binary16 and binary32 formats.
// ----------------------------------------------------------------------------
// One request enters per cycle when the output is not stalled; the pipeline
// has three register stages (decode to binary32, target conversion, output),
// and throughput is one sample per clock when the output is not stalled. A
// stall at the output freezes every stage together, so nothing is lost or
// repeated. The two format registers sit at byte addresses 0 and 4 of the
// configuration port and should only be written while the pipe is empty.
// Any pair involving format 3 returns status 1 with a zero word.
module pixel_sample_type_converter
  import pstc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_word,
  input  logic        in_final_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_converted_word,
  output logic        out_status,
  output logic        out_final_out,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0] src_r, dst_r;
  logic       en;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, (cfg_paddr[2] ? dst_r : src_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= FMT_HALF;
      dst_r <= FMT_FLOAT;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == 3'd0) src_r <= cfg_pwdata[1:0];
      if (cfg_paddr == 3'd4) dst_r <= cfg_pwdata[1:0];
    end
  end

  // The whole pipe advances together unless the output register is stalled.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: bring the source into binary32 and pre-compute the unorm path.
  logic        v1_r, fin1_r, bad1_r, same1_r;
  logic [31:0] fl1_r, raw1_r;
  logic [31:0] w;
  logic [31:0] u2f;
  logic [4:0]  p;
  logic [31:0] um, ur, uhw;
  logic [4:0]  s;
  logic [31:0] fl1_nxt;

  always_comb begin
    w   = in_sample_word;
    p   = lead_one(w);
    s   = p - 5'd23;
    um  = 32'd0;
    ur  = 32'd0;
    uhw = 32'd0;
    if (p <= 5'd23) begin
      um = w << (5'd23 - p);
    end else begin
      um  = w >> s;
      ur  = w & ((32'd1 << s) - 32'd1);
      uhw = 32'd1 << (s - 5'd1);
      if (ur > uhw || (ur == uhw && um[0])) um = um + 32'd1;
    end
    u2f = (w == 32'd0) ? 32'd0 : ({1'b0, 8'({3'd0, p} + 8'd94), 23'd0} + um);
    case (src_r)
      FMT_HALF:  fl1_nxt = expand_half(w[15:0]);
      FMT_UNORM: fl1_nxt = u2f;
      default:   fl1_nxt = w;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin1_r  <= in_final_sample;
      bad1_r  <= (src_r == FMT_NONE) || (dst_r == FMT_NONE);
      same1_r <= src_r == dst_r;
      raw1_r  <= (src_r == FMT_HALF) ? {16'd0, w[15:0]} : w;
      fl1_r   <= fl1_nxt;
    end
  end

  // Stage 2: convert the binary32 value to the target format.
  logic        v2_r, fin2_r, bad2_r, same2_r;
  logic [31:0] fl2_r, raw2_r, un2_r, un2_nxt;
  logic [15:0] h2_r;
  logic [7:0]  fe;

  pstc_to_half u_half (
    .clk (clk),
    .en  (en),
    .f   (fl1_r),
    .h_r (h2_r)
  );

  always_comb begin
    fe = fl1_r[30:23];
    if (fl1_r[31] || fl1_r > 32'h7f80_0000) un2_nxt = 32'd0;
    else if (fl1_r >= 32'h3f80_0000) un2_nxt = 32'hffff_ffff;
    else if (fe == 8'd0) un2_nxt = 32'd0;
    else if (fe >= 8'd118) un2_nxt = {8'd0, 1'b1, fl1_r[22:0]} << 5'(fe - 8'd118);
    else if (8'd118 - fe >= 8'd32) un2_nxt = 32'd0;
    else un2_nxt = {8'd0, 1'b1, fl1_r[22:0]} >> 5'(8'd118 - fe);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin2_r  <= fin1_r;
      bad2_r  <= bad1_r;
      same2_r <= same1_r;
      raw2_r  <= raw1_r;
      fl2_r   <= fl1_r;
      un2_r   <= un2_nxt;
    end
  end

  // Stage 3: output register, selected by pair status and target format.
  logic [31:0] res_nxt;
  logic        dst_ok;

  assign dst_ok = 1'b1;

  always_comb begin
    if (bad2_r) res_nxt = 32'd0;
    else if (same2_r) res_nxt = raw2_r;
    else begin
      case (dst_r)
        FMT_HALF:  res_nxt = {16'd0, h2_r};
        FMT_UNORM: res_nxt = un2_r;
        default:   res_nxt = fl2_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= v2_r && dst_ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_converted_word <= res_nxt;
      out_status         <= bad2_r;
      out_final_out      <= fin2_r;
    end
  end

  // An unsupported pair always comes out as a zero word.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_converted_word == 32'd0)
    else $error("unsupported pair gave a non-zero word");

  // A stalled result stays in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_converted_word))
    else $error("stalled result changed");

  // The pipe takes no request while a valid output result is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken during output stall");

endmodule

>>> hdl/pstc_to_half.sv
// ----------------------------------------------------------------------------
// Float to half rounding stage
// Registered rounding of a binary32 word to binary16, nearest even.
// ----------------------------------------------------------------------------
module pstc_to_half
  import pstc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] f,
  output logic [15:0] h_r
);

  logic [15:0] h_nxt;
  logic [30:0] a;
  logic [15:0] sgn;
  logic [9:0]  nm;
  logic [14:0] hn;
  logic [12:0] rem;
  logic [23:0] mm;
  logic [4:0]  sh;
  logic [23:0] hs, rs, hw;

  always_comb begin
    a   = f[30:0];
    sgn = {f[31], 15'd0};
    nm  = f[22:13];
    hn  = 15'({5'(f[30:23] - 8'd112), f[22:13]});
    rem = f[12:0];
    mm  = {1'b1, f[22:0]};
    sh  = 5'(8'd126 - f[30:23]);
    hs  = mm >> sh;
    rs  = mm & ((24'd1 << sh) - 24'd1);
    hw  = 24'd1 << (sh - 5'd1);
    if (a > 31'h7f80_0000) begin
      h_nxt = sgn | 16'h7c00 | {6'd0, nm} | {15'd0, (nm == 10'd0)};
    end else if (a >= 31'h477f_f000) begin
      h_nxt = sgn | 16'h7c00;
    end else if (a >= 31'h3880_0000) begin
      if (rem > 13'h1000 || (rem == 13'h1000 && hn[0])) hn = hn + 15'd1;
      h_nxt = sgn | {1'b0, hn};
    end else if (a < 31'h3300_0000) begin
      h_nxt = sgn;
    end else begin
      if (rs > hw || (rs == hw && hs[0])) hs = hs + 24'd1;
      h_nxt = sgn | hs[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) h_r <= h_nxt;
  end

endmodule

>>> sim/pixel_sample_type_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel sample type converter testbench
// Drives sample requests under every pair of source and target formats. A
// local bit-level model predicts each result, and each result is compared
// with the prediction in order. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module pixel_sample_type_converter_test
  import pstc_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_sample_word;
  logic        in_final_sample;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_converted_word;
  logic        out_status;
  logic        out_final_out;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // One expected result: the converted word, the status and the final flag.
  typedef struct packed {
    logic [31:0] word;
    logic        status;
    logic        final_flag;
  } conv_result_t;

  conv_result_t expected_results[$];

  // Local copy of the two format registers, updated with every write.
  fmt_t src_fmt;
  fmt_t dst_fmt;

  int mismatch_count;
  int result_count;
  int request_count;
  bit stall_enable;

  pixel_sample_type_converter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_word     (in_sample_word),
    .in_final_sample    (in_final_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_converted_word (out_converted_word),
    .out_status         (out_status),
    .out_final_out      (out_final_out),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction. Every conversion works on the bit patterns alone.
  // --------------------------------------------------------------------------

  // Half to float widens exactly; a subnormal half is normalised by shifting
  // its mantissa up until the hidden bit appears.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [10:0] m;
    logic [7:0]  fe;
    sgn = {h[15], 31'd0};
    e   = h[14:10];
    m   = {1'b0, h[9:0]};
    if (e == 5'h1f) return sgn | 32'h7f80_0000 | {9'd0, m[9:0], 13'd0};
    if (e == 5'd0) begin
      if (m == 11'd0) return sgn;
      fe = 8'd113;
      while (m[10] == 1'b0) begin
        m  = m << 1;
        fe = fe - 8'd1;
      end
      return sgn | {1'b0, fe, m[9:0], 13'd0};
    end
    return sgn | {1'b0, 8'({3'd0, e} + 8'd112), m[9:0], 13'd0};
  endfunction

  // Float to half rounds to nearest even, saturates to infinity and sets the
  // low payload bit of a NaN whose kept payload would otherwise vanish.
  function automatic logic [15:0] narrow_float(input logic [31:0] f);
    logic [15:0] sgn;
    logic [31:0] a;
    logic [31:0] h;
    logic [31:0] rem;
    logic [31:0] halfway;
    logic [31:0] shift;
    logic [31:0] m;
    sgn = {f[31], 15'd0};
    a   = f & 32'h7fff_ffff;
    if (a > 32'h7f80_0000) begin
      m = (a & 32'h007f_ffff) >> 13;
      return sgn | 16'h7c00 | m[15:0] | ((m == 0) ? 16'd1 : 16'd0);
    end
    if (a >= 32'h477f_f000) return sgn | 16'h7c00;
    if (a >= 32'h3880_0000) begin
      h   = (((a >> 23) - 32'd112) << 10) | ((a & 32'h007f_ffff) >> 13);
      rem = a & 32'h1fff;
      if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
      return sgn | h[15:0];
    end
    if (a < 32'h3300_0000) return sgn;
    m       = (a & 32'h007f_ffff) | 32'h0080_0000;
    shift   = 32'd126 - (a >> 23);
    h       = m >> shift;
    rem     = m & ((32'd1 << shift) - 1);
    halfway = 32'd1 << (shift - 1);
    if (rem > halfway || (rem == halfway && h[0])) h = h + 1;
    return sgn | h[15:0];
  endfunction

  // Unorm to float: round the integer to 24 significant bits, then scale by
  // 2^-32, which only moves the exponent.
  function automatic logic [31:0] unorm_as_float(input logic [31:0] u);
    int          p;
    logic [31:0] m;
    logic [31:0] rem;
    logic [31:0] halfway;
    int          s;
    if (u == 0) return 32'd0;
    p = 31;
    while (u[p] == 1'b0) p--;
    if (p <= 23) begin
      m = u << (23 - p);
    end else begin
      s       = p - 23;
      m       = u >> s;
      rem     = u & ((32'd1 << s) - 1);
      halfway = 32'd1 << (s - 1);
      if (rem > halfway || (rem == halfway && m[0])) m = m + 1;
    end
    return ((32'(p) + 32'd94) << 23) + m;
  endfunction

  // Float to unorm truncates the value times 2^32; negatives and NaNs give
  // zero, one and above give all ones.
  function automatic logic [31:0] float_as_unorm(input logic [31:0] f);
    logic [31:0] e;
    logic [31:0] m;
    if (f[31] || f > 32'h7f80_0000) return 32'd0;
    if (f >= 32'h3f80_0000) return 32'hffff_ffff;
    e = f >> 23;
    if (e == 0) return 32'd0;
    m = (f & 32'h007f_ffff) | 32'h0080_0000;
    if (e >= 118) return m << (e - 118);
    if (118 - e >= 32) return 32'd0;
    return m >> (118 - e);
  endfunction

  function automatic conv_result_t convert_sample(input logic [31:0] w,
                                                  input logic        fin);
    conv_result_t r;
    logic [31:0]  fl;
    r.word       = 32'd0;
    r.status     = 1'b0;
    r.final_flag = fin;
    if (src_fmt == FMT_NONE || dst_fmt == FMT_NONE) begin
      r.status = 1'b1;
    end else if (src_fmt == dst_fmt) begin
      r.word = (src_fmt == FMT_HALF) ? {16'd0, w[15:0]} : w;
    end else begin
      if (src_fmt == FMT_HALF) fl = widen_half(w[15:0]);
      else if (src_fmt == FMT_UNORM) fl = unorm_as_float(w);
      else fl = w;
      if (dst_fmt == FMT_FLOAT) r.word = fl;
      else if (dst_fmt == FMT_HALF) r.word = {16'd0, narrow_float(fl)};
      else r.word = float_as_unorm(fl);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Sends one request and records its prediction once it has been accepted.
  // Valid stays high across back-to-back requests, so it is only lowered
  // when a gap follows.
  task automatic send_sample(input logic [31:0] w, input logic fin,
                             input bit use_gaps);
    int gap;
    gap = use_gaps ? gap_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_word  <= w;
    in_final_sample <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(convert_sample(w, fin));
    request_count++;
  endtask

  // Waits for the pipe to drain, then allows the pipeline latency to pass
  // before any register write.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write: setup cycle, then the access cycle; pready is always high.
  // The bus then returns to idle so that the next write starts cleanly.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_formats(input fmt_t s, input fmt_t d);
    drain_pipe();
    write_register(3'd0, {30'd0, s});
    write_register(3'd4, {30'd0, d});
    src_fmt = s;
    dst_fmt = d;
  endtask

  // Random sample shaped for the source format, so that special values
  // (zeros, subnormals, infinities, NaNs, values near one) turn up often.
  function automatic logic [31:0] random_sample();
    logic [31:0] w;
    int          kind;
    w    = $urandom();
    kind = $urandom_range(9);
    case (src_fmt)
      FMT_HALF: begin
        if (kind == 0) w[14:10] = 5'h1f;
        else if (kind == 1) w[14:10] = 5'h00;
        else if (kind == 2) w[14:10] = 5'(14 + $urandom_range(1));
      end
      FMT_FLOAT: begin
        if (kind == 0) w[30:23] = 8'hff;
        else if (kind == 1) w[30:23] = 8'h00;
        else if (kind <= 4) w[30:23] = 8'(102 + $urandom_range(40));
        else if (kind == 5) w[30:23] = 8'(110 + $urandom_range(17));
      end
      default: begin
        if (kind < 3) w = w >> $urandom_range(31);
      end
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking, with a random stall on the result side.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result word=%h status=%b final=%b",
                   out_converted_word, out_status, out_final_out);
      end else begin
        want = expected_results.pop_front();
        if (out_converted_word !== want.word || out_status !== want.status ||
            out_final_out !== want.final_flag) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d expected %h/%b/%b got %h/%b/%b",
                     result_count, want.word, want.status, want.final_flag,
                     out_converted_word, out_status, out_final_out);
        end
      end
    end
  end

  // The stall holds for a random stretch, then is re-drawn; a stretch with
  // the stall released is common so that full-rate runs also occur.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || !stall_enable) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(99) < 30);
      stall_left <= gap_length();
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Directed edge values under the conversions that carry special cases.
  task automatic test_directed();
    set_formats(FMT_HALF, FMT_FLOAT);
    send_sample(32'h0000_0000, 1'b0, 0);
    send_sample(32'hffff_8001, 1'b1, 0);   // negative subnormal, upper bits set
    send_sample(32'h0000_7c00, 1'b0, 0);   // infinity
    send_sample(32'h0000_7e01, 1'b0, 0);   // NaN payload
    send_sample(32'h0000_7bff, 1'b0, 0);
    set_formats(FMT_FLOAT, FMT_HALF);
    send_sample(32'h477f_f000, 1'b0, 0);   // rounds to infinity
    send_sample(32'h3880_1000, 1'b0, 0);   // tie to even
    send_sample(32'h3300_0001, 1'b0, 0);   // smallest subnormal after rounding
    send_sample(32'h7f80_0001, 1'b0, 0);   // NaN whose kept payload is zero
    send_sample(32'hffff_ffff, 1'b1, 0);
    set_formats(FMT_UNORM, FMT_HALF);
    send_sample(32'hffff_ffff, 1'b0, 0);
    send_sample(32'h0000_0001, 1'b0, 0);
    send_sample(32'h8000_0080, 1'b0, 0);   // tie in the integer rounding
    set_formats(FMT_FLOAT, FMT_UNORM);
    send_sample(32'h8000_0000, 1'b0, 0);   // negative zero
    send_sample(32'h3f80_0000, 1'b0, 0);   // exactly one
    send_sample(32'h7f80_0000, 1'b0, 0);   // +infinity
    send_sample(32'h7fc0_0000, 1'b0, 0);   // NaN
    send_sample(32'h3f7f_ffff, 1'b1, 0);
    set_formats(FMT_NONE, FMT_NONE);
    send_sample(32'h1234_5678, 1'b1, 0);   // unsupported pair keeps final flag
  endtask

  // Random requests under every one of the sixteen format pairs.
  task automatic test_all_pairs(input int per_pair);
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 4; d++) begin
        set_formats(fmt_t'(s), fmt_t'(d));
        stall_enable = ($urandom_range(3) != 0);
        for (int i = 0; i < per_pair; i++)
          send_sample(random_sample(), $urandom_range(1), stall_enable);
      end
    end
    stall_enable = 1'b1;
  endtask

  // Random formats drawn phase by phase, including upper value bits that
  // the registers must drop.
  task automatic test_random_phases(input int phases, input int per_phase);
    logic [31:0] s;
    logic [31:0] d;
    for (int p = 0; p < phases; p++) begin
      drain_pipe();
      s = $urandom();
      d = $urandom();
      write_register(3'd0, s);
      write_register(3'd4, d);
      src_fmt = fmt_t'(s[1:0]);
      dst_fmt = fmt_t'(d[1:0]);
      for (int i = 0; i < per_phase; i++)
        send_sample(random_sample(), $urandom_range(1), 1'b1);
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_word  = 32'd0;
    in_final_sample = 1'b0;
    out_stall       = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = 3'd0;
    cfg_pwdata      = 32'd0;
    src_fmt         = FMT_HALF;
    dst_fmt         = FMT_FLOAT;
    mismatch_count  = 0;
    result_count    = 0;
    request_count   = 0;
    stall_enable    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset formats are half to float; check them before any write.
    send_sample(32'h0000_3c00, 1'b0, 0);
    stall_enable = 1'b1;
    test_directed();
    test_all_pairs(80);
    test_random_phases(12, 50);
    drain_pipe();

    $display("Covered %0d requests and %0d results over all sixteen format pairs,",
             request_count, result_count);
    $display("with random idling on both sides; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS pixel_sample_type_converter");
    end else begin
      $display("FAIL pixel_sample_type_converter");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL pixel_sample_type_converter");
    $finish;
  end

endmodule

>>> filelist.f
hdl/pstc_pkg.sv
hdl/pstc_to_half.sv
hdl/pixel_sample_type_converter.sv
sim/pixel_sample_type_converter_test.sv
